/* rtl/owps_pkg.sv */
// Package for the one-wire poll sequencer: request and result types,
// mode, action and request codes, and configuration register indexes.
// No dependencies.
`default_nettype none

package owps_pkg;

    localparam int TIMER_W     = 24;
    localparam int CMD_W       = 8;
    localparam int SLOT_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BROADCAST_COMMAND = 1'd1;

    localparam logic [TIMER_W-1:0] POLL_INTERVAL_RESET     = 24'd1000;
    localparam logic [CMD_W-1:0]   BROADCAST_COMMAND_RESET = 8'd68;
    localparam logic [TIMER_W-1:0] TIMER_MAX               = 24'hFFFFFF;

    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_LOCK_ANS = 3'd1;
    localparam logic [2:0] REQ_BCAST_ST = 3'd2;
    localparam logic [2:0] REQ_POLL_ST  = 3'd3;
    localparam logic [2:0] REQ_ADD      = 3'd4;
    localparam logic [2:0] REQ_DELETE   = 3'd5;
    localparam logic [2:0] REQ_RETIME   = 3'd6;

    localparam logic [1:0] STATUS_BUSY = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_LOCK    = 4'd1;
    localparam logic [3:0] ACT_BCAST   = 4'd2;
    localparam logic [3:0] ACT_POLL    = 4'd3;
    localparam logic [3:0] ACT_STAMP   = 4'd4;
    localparam logic [3:0] ACT_FAILALL = 4'd5;
    localparam logic [3:0] ACT_FAILONE = 4'd6;
    localparam logic [3:0] ACT_RELEASE = 4'd7;
    localparam logic [3:0] ACT_RESTART = 4'd8;

    localparam logic [2:0] MODE_CODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_CODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_CODE_LOCK  = 3'd2;
    localparam logic [2:0] MODE_CODE_BCAST = 3'd3;
    localparam logic [2:0] MODE_CODE_CONV  = 3'd4;
    localparam logic [2:0] MODE_CODE_POLL  = 3'd5;

    typedef enum logic [5:0] {
        MODE_OFF   = 6'b000001,
        MODE_WAIT  = 6'b000010,
        MODE_LOCK  = 6'b000100,
        MODE_BCAST = 6'b001000,
        MODE_CONV  = 6'b010000,
        MODE_POLL  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         status;
        logic               granted;
        logic [SLOT_W-1:0]  slave_slot;
        logic [TIMER_W-1:0] wait_interval;
    } event_t;

    typedef struct packed {
        logic [3:0]        action;
        logic [SLOT_W-1:0] target_slot;
        logic [CMD_W-1:0]  command_out;
        logic              accepted;
        logic [2:0]        mode_out;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/onewire_poll_sequencer.sv */
// Top level of the one-wire poll sequencer: event decoding, mode control,
// timer and slot table. Depends on owps_pkg and owps_result_queue.
//
// Usage: events (ticks, lock answers, bus statuses, add, delete, retime)
// arrive on the evt channel as one request each. A request is taken at a
// rising edge with evt_valid high and evt_stall low. Every request yields
// one or two results on the res channel, in order, the last one marked.
// The request is decoded and the mode, timer and slot table updated in the
// cycle it is taken; its results are written into the result queue.
// Up to one request per cycle is taken, while evt_stall is low. A request
// that yields two results hands them to the result port one after the
// other, so the sustained rate is one request per cycle for single-result
// requests; the four-entry result queue sets evt_stall once fewer than two
// entries are free. When the receiver holds res_stall, results wait in the
// queue and evt_stall rises once three entries are taken. Configuration
// writes take effect at the next edge.
// Reset empties the queue, sets the mode to off, clears the timer, the slot
// table and the largest conversion time, and loads the register defaults.
`default_nettype none

module onewire_poll_sequencer #(
    parameter int SLOTS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [owps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [owps_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                                evt_valid,
    output logic                                     evt_stall,
    input  wire owps_pkg::event_t                    evt_data,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output owps_pkg::result_t                        res_data
);

    localparam int UsedSlots = (SLOTS < 8) ? SLOTS : 8;

    logic [owps_pkg::TIMER_W-1:0] poll_interval_reg;
    logic [owps_pkg::CMD_W-1:0]   bcast_cmd_reg;

    owps_pkg::mode_t              mode_reg, mode_next;
    logic [owps_pkg::TIMER_W-1:0] timer_count_reg, timer_count_next;
    logic [owps_pkg::TIMER_W-1:0] timer_limit_reg, timer_limit_next;
    logic [owps_pkg::SLOT_W-1:0]  cur_slot_reg, cur_slot_next;
    logic [UsedSlots-1:0]         present_reg, present_next;
    logic [owps_pkg::TIMER_W-1:0] max_wait_reg, max_wait_next;

    logic                         take;
    logic [UsedSlots-1:0]         slot_onehot;
    logic [UsedSlots-1:0]         cur_onehot;
    logic                         slot_ok;
    logic                         slot_here;
    logic [owps_pkg::TIMER_W-1:0] tick_count;
    logic                         expire;
    logic [3:0]                   search_from;
    logic [UsedSlots-1:0]         search_mask;
    logic                         found;
    logic [owps_pkg::SLOT_W-1:0]  found_slot;
    logic [3:0]                   pf_action;
    logic [owps_pkg::SLOT_W-1:0]  pf_slot;
    logic                         pf_poll;

    logic [3:0]                   act0, act1;
    logic [owps_pkg::SLOT_W-1:0]  tgt0, tgt1;
    logic [owps_pkg::CMD_W-1:0]   cmd0;
    logic                         two;
    logic                         acc;
    logic [2:0]                   mode_code;

    owps_pkg::result_t            res_first, res_second;
    logic [1:0]                   push_cnt;
    logic                         queue_full;

    assign take = evt_valid && !evt_stall;

    always_comb
    begin
        for (int i = 0; i < UsedSlots; i++)
        begin
            slot_onehot[i] = (evt_data.slave_slot == owps_pkg::SLOT_W'(i));
            cur_onehot[i]  = (cur_slot_reg == owps_pkg::SLOT_W'(i));
        end
    end

    assign slot_ok   = |slot_onehot;
    assign slot_here = |(present_reg & slot_onehot);

    assign tick_count = (timer_count_reg != owps_pkg::TIMER_MAX)
                        ? timer_count_reg + owps_pkg::TIMER_W'(1) : timer_count_reg;
    assign expire     = (tick_count >= timer_limit_reg);

    always_comb
    begin
        case (evt_data.req_type)
            owps_pkg::REQ_POLL_ST: search_from = {1'b0, cur_slot_reg} + 4'd1;
            owps_pkg::REQ_DELETE:  search_from = {1'b0, evt_data.slave_slot} + 4'd1;
            default:               search_from = 4'd0;
        endcase
        search_mask = present_reg;
        if (evt_data.req_type == owps_pkg::REQ_DELETE)
        begin
            search_mask = present_reg & ~slot_onehot;
        end
        found      = 1'b0;
        found_slot = '0;
        for (int i = UsedSlots - 1; i >= 0; i--)
        begin
            if (search_mask[i] && 4'(i) >= search_from)
            begin
                found      = 1'b1;
                found_slot = owps_pkg::SLOT_W'(i);
            end
        end
        pf_poll   = found;
        pf_action = found ? owps_pkg::ACT_POLL : owps_pkg::ACT_RELEASE;
        pf_slot   = found ? found_slot : '0;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        timer_count_next = timer_count_reg;
        timer_limit_next = timer_limit_reg;
        cur_slot_next    = cur_slot_reg;
        present_next     = present_reg;
        max_wait_next    = max_wait_reg;
        act0 = owps_pkg::ACT_NONE;
        tgt0 = '0;
        cmd0 = '0;
        act1 = owps_pkg::ACT_NONE;
        tgt1 = '0;
        two  = 1'b0;
        acc  = 1'b0;

        case (evt_data.req_type)
            owps_pkg::REQ_TICK:
            begin
                if (mode_reg == owps_pkg::MODE_WAIT)
                begin
                    timer_count_next = expire ? '0 : tick_count;
                    if (expire)
                    begin
                        mode_next = owps_pkg::MODE_LOCK;
                        act0      = owps_pkg::ACT_LOCK;
                    end
                end
                else if (mode_reg == owps_pkg::MODE_LOCK)
                begin
                    act0 = owps_pkg::ACT_LOCK;
                end
                else if (mode_reg == owps_pkg::MODE_CONV)
                begin
                    timer_count_next = expire ? '0 : tick_count;
                    if (expire)
                    begin
                        act0 = pf_action;
                        tgt0 = pf_slot;
                        if (pf_poll)
                        begin
                            cur_slot_next = pf_slot;
                            mode_next     = owps_pkg::MODE_POLL;
                        end
                        else
                        begin
                            timer_limit_next = poll_interval_reg;
                            timer_count_next = '0;
                            mode_next        = owps_pkg::MODE_WAIT;
                        end
                    end
                end
            end
            owps_pkg::REQ_LOCK_ANS:
            begin
                if (mode_reg == owps_pkg::MODE_LOCK && evt_data.granted)
                begin
                    mode_next = owps_pkg::MODE_BCAST;
                    act0      = owps_pkg::ACT_BCAST;
                    cmd0      = bcast_cmd_reg;
                end
            end
            owps_pkg::REQ_BCAST_ST:
            begin
                if (mode_reg == owps_pkg::MODE_BCAST
                    && evt_data.status != owps_pkg::STATUS_BUSY)
                begin
                    timer_count_next = '0;
                    if (evt_data.status == owps_pkg::STATUS_DONE)
                    begin
                        timer_limit_next = max_wait_reg;
                        mode_next        = owps_pkg::MODE_CONV;
                        act0             = owps_pkg::ACT_STAMP;
                    end
                    else
                    begin
                        mode_next = owps_pkg::MODE_WAIT;
                        act0      = owps_pkg::ACT_FAILALL;
                        act1      = owps_pkg::ACT_RELEASE;
                        two       = 1'b1;
                    end
                end
            end
            owps_pkg::REQ_POLL_ST:
            begin
                if (mode_reg == owps_pkg::MODE_POLL
                    && evt_data.status != owps_pkg::STATUS_BUSY)
                begin
                    if (evt_data.status != owps_pkg::STATUS_DONE)
                    begin
                        act0 = owps_pkg::ACT_FAILONE;
                        tgt0 = cur_slot_reg;
                        act1 = pf_action;
                        tgt1 = pf_slot;
                        two  = 1'b1;
                    end
                    else
                    begin
                        act0 = pf_action;
                        tgt0 = pf_slot;
                    end
                    if (pf_poll)
                    begin
                        cur_slot_next = pf_slot;
                    end
                    else
                    begin
                        timer_limit_next = poll_interval_reg;
                        timer_count_next = '0;
                        mode_next        = owps_pkg::MODE_WAIT;
                    end
                end
            end
            owps_pkg::REQ_ADD:
            begin
                if (slot_ok && !slot_here)
                begin
                    present_next = present_reg | slot_onehot;
                    acc          = 1'b1;
                    if (evt_data.wait_interval > max_wait_reg)
                    begin
                        max_wait_next = evt_data.wait_interval;
                    end
                    if (mode_reg == owps_pkg::MODE_OFF)
                    begin
                        timer_limit_next = poll_interval_reg;
                        timer_count_next = '0;
                        mode_next        = owps_pkg::MODE_WAIT;
                    end
                end
            end
            owps_pkg::REQ_DELETE:
            begin
                if (slot_here)
                begin
                    present_next = present_reg & ~slot_onehot;
                    acc          = 1'b1;
                    if (mode_reg == owps_pkg::MODE_POLL
                        && cur_slot_reg == evt_data.slave_slot)
                    begin
                        act0 = owps_pkg::ACT_RESTART;
                        act1 = pf_action;
                        tgt1 = pf_slot;
                        two  = 1'b1;
                        if (pf_poll)
                        begin
                            cur_slot_next = pf_slot;
                        end
                        else
                        begin
                            timer_limit_next = poll_interval_reg;
                            timer_count_next = '0;
                            mode_next        = owps_pkg::MODE_WAIT;
                        end
                    end
                end
            end
            owps_pkg::REQ_RETIME:
            begin
                if (slot_here && evt_data.wait_interval > max_wait_reg)
                begin
                    max_wait_next = evt_data.wait_interval;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (mode_next)
            owps_pkg::MODE_OFF:   mode_code = owps_pkg::MODE_CODE_OFF;
            owps_pkg::MODE_WAIT:  mode_code = owps_pkg::MODE_CODE_WAIT;
            owps_pkg::MODE_LOCK:  mode_code = owps_pkg::MODE_CODE_LOCK;
            owps_pkg::MODE_BCAST: mode_code = owps_pkg::MODE_CODE_BCAST;
            owps_pkg::MODE_CONV:  mode_code = owps_pkg::MODE_CODE_CONV;
            owps_pkg::MODE_POLL:  mode_code = owps_pkg::MODE_CODE_POLL;
            default:              mode_code = owps_pkg::MODE_CODE_OFF;
        endcase
    end

    always_comb
    begin
        res_first.action       = act0;
        res_first.target_slot  = tgt0;
        res_first.command_out  = cmd0;
        res_first.accepted     = acc;
        res_first.mode_out     = mode_code;
        res_first.last         = !two;
        res_second.action      = act1;
        res_second.target_slot = tgt1;
        res_second.command_out = '0;
        res_second.accepted    = acc;
        res_second.mode_out    = mode_code;
        res_second.last        = 1'b1;
        if (!take)
        begin
            push_cnt = 2'd0;
        end
        else if (two)
        begin
            push_cnt = 2'd2;
        end
        else
        begin
            push_cnt = 2'd1;
        end
    end

    owps_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_first  (res_first),
        .push_second (res_second),
        .pop         (res_valid && !res_stall),
        .head        (res_data),
        .nonempty    (res_valid),
        .no_room     (queue_full)
    );

    assign evt_stall = queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= owps_pkg::POLL_INTERVAL_RESET;
            bcast_cmd_reg     <= owps_pkg::BROADCAST_COMMAND_RESET;
            mode_reg          <= owps_pkg::MODE_OFF;
            timer_count_reg   <= '0;
            timer_limit_reg   <= '0;
            cur_slot_reg      <= '0;
            present_reg       <= '0;
            max_wait_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == owps_pkg::CFG_POLL_INTERVAL)
            begin
                poll_interval_reg <= cfg_wr_data[owps_pkg::TIMER_W-1:0];
            end
            if (cfg_wr_en && cfg_index == owps_pkg::CFG_BROADCAST_COMMAND)
            begin
                bcast_cmd_reg <= cfg_wr_data[owps_pkg::CMD_W-1:0];
            end
            if (take)
            begin
                mode_reg        <= mode_next;
                timer_count_reg <= timer_count_next;
                timer_limit_reg <= timer_limit_next;
                cur_slot_reg    <= cur_slot_next;
                present_reg     <= present_next;
                max_wait_reg    <= max_wait_next;
            end
        end
    end

    // While polling, the slot being polled is always a present device.
    a_poll_slot_present: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mode_reg == owps_pkg::MODE_POLL) |-> |(present_reg & cur_onehot)
    ) else $error("polled slot is not present");

    // The timer is cleared whenever it reaches its limit.
    a_timer_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        timer_count_reg <= timer_limit_reg
    ) else $error("timer count above its limit");

    // Every taken request leaves at least one result waiting.
    a_request_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> res_valid
    ) else $error("request produced no result");

endmodule

`default_nettype wire

/* rtl/owps_result_queue.sv */
// Result queue of the poll sequencer: a short shift queue that takes one or
// two results per cycle and hands them out in order. Depends on owps_pkg.
`default_nettype none

module owps_result_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_cnt,
    input  wire owps_pkg::result_t push_first,
    input  wire owps_pkg::result_t push_second,
    input  wire logic             pop,
    output owps_pkg::result_t     head,
    output logic                  nonempty,
    output logic                  no_room
);

    owps_pkg::result_t q_reg [owps_pkg::QUEUE_DEPTH];
    owps_pkg::result_t q_next [owps_pkg::QUEUE_DEPTH];
    logic [owps_pkg::QCOUNT_W-1:0] cnt_reg;
    logic [owps_pkg::QCOUNT_W-1:0] cnt_next;
    logic [owps_pkg::QCOUNT_W-1:0] cnt_after_pop;

    assign nonempty = (cnt_reg != '0);
    assign no_room  = (cnt_reg > owps_pkg::QCOUNT_W'(owps_pkg::QUEUE_DEPTH - 2));
    assign head     = q_reg[0];

    always_comb
    begin
        cnt_after_pop = cnt_reg - owps_pkg::QCOUNT_W'(pop);
        for (int i = 0; i < owps_pkg::QUEUE_DEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[owps_pkg::QUEUE_DEPTH-1] = q_reg[owps_pkg::QUEUE_DEPTH-1];
        for (int i = 0; i < owps_pkg::QUEUE_DEPTH; i++)
        begin
            if (push_cnt != 2'd0 && cnt_after_pop == owps_pkg::QCOUNT_W'(i))
            begin
                q_next[i] = push_first;
            end
            if (push_cnt == 2'd2
                && cnt_after_pop + owps_pkg::QCOUNT_W'(1) == owps_pkg::QCOUNT_W'(i))
            begin
                q_next[i] = push_second;
            end
        end
        cnt_next = cnt_after_pop + owps_pkg::QCOUNT_W'(push_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < owps_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for onewire_poll_sequencer: drives event requests,
// predicts every result with its own model of the sequencer and checks them.
// Depends on owps_pkg and the sequencer RTL.
module testbench;

    localparam int SLOTS = 8;

    localparam logic [1:0] STATUS_FAILED   = 2'd2;
    localparam logic [1:0] STATUS_RESERVED = 2'd3;
    localparam logic [2:0] REQ_RESERVED    = 3'd7;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [owps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [owps_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                             evt_valid = 1'b0;
    logic                             evt_stall;
    owps_pkg::event_t                 evt_data = '0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    owps_pkg::result_t                res_data;

    onewire_poll_sequencer #(.SLOTS(SLOTS)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt_data    (evt_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

    owps_pkg::event_t  pending_events[$];
    owps_pkg::result_t expected_results[$];
    owps_pkg::result_t staged[$];
    int                taken_count = 0;
    int                errors = 0;

    logic [2:0]                   m_mode = owps_pkg::MODE_CODE_OFF;
    logic [owps_pkg::TIMER_W-1:0] m_count = '0;
    logic [owps_pkg::TIMER_W-1:0] m_limit = '0;
    int                           m_slot = 0;
    logic [SLOTS-1:0]             m_present = '0;
    logic [owps_pkg::TIMER_W-1:0] m_max_wait = '0;
    logic [owps_pkg::TIMER_W-1:0] m_interval = owps_pkg::POLL_INTERVAL_RESET;
    logic [owps_pkg::CMD_W-1:0]   m_command = owps_pkg::BROADCAST_COMMAND_RESET;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("** onewire_poll_sequencer: FAILED **");
        $finish;
    end

    task automatic emit(input logic [3:0] act, input int tgt,
                        input logic [owps_pkg::CMD_W-1:0] cmd);
        owps_pkg::result_t r;
        r = '0;
        r.action = act;
        r.target_slot = tgt[owps_pkg::SLOT_W-1:0];
        r.command_out = cmd;
        staged.push_back(r);
    endtask

    function automatic bit timer_expired();
        if (m_count < owps_pkg::TIMER_MAX) m_count++;
        if (m_count >= m_limit)
        begin
            m_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic poll_next(input int from);
        int i;
        i = from;
        while (i < SLOTS && !m_present[i]) i++;
        if (i < SLOTS)
        begin
            m_slot = i;
            m_mode = owps_pkg::MODE_CODE_POLL;
            emit(owps_pkg::ACT_POLL, i, '0);
        end
        else
        begin
            m_limit = m_interval;
            m_count = '0;
            m_mode = owps_pkg::MODE_CODE_WAIT;
            emit(owps_pkg::ACT_RELEASE, 0, '0);
        end
    endtask

    task automatic predict_event(input owps_pkg::event_t ev);
        logic acc;
        int   s;
        acc = 1'b0;
        s = ev.slave_slot;
        staged.delete();
        case (ev.req_type)
            owps_pkg::REQ_TICK:
            begin
                if (m_mode == owps_pkg::MODE_CODE_WAIT)
                begin
                    if (timer_expired())
                    begin
                        m_mode = owps_pkg::MODE_CODE_LOCK;
                        emit(owps_pkg::ACT_LOCK, 0, '0);
                    end
                end
                else if (m_mode == owps_pkg::MODE_CODE_LOCK)
                begin
                    emit(owps_pkg::ACT_LOCK, 0, '0);
                end
                else if (m_mode == owps_pkg::MODE_CODE_CONV)
                begin
                    if (timer_expired()) poll_next(0);
                end
            end
            owps_pkg::REQ_LOCK_ANS:
            begin
                if (m_mode == owps_pkg::MODE_CODE_LOCK && ev.granted)
                begin
                    m_mode = owps_pkg::MODE_CODE_BCAST;
                    emit(owps_pkg::ACT_BCAST, 0, m_command);
                end
            end
            owps_pkg::REQ_BCAST_ST:
            begin
                if (m_mode == owps_pkg::MODE_CODE_BCAST && ev.status != owps_pkg::STATUS_BUSY)
                begin
                    if (ev.status == owps_pkg::STATUS_DONE)
                    begin
                        m_limit = m_max_wait;
                        m_count = '0;
                        m_mode = owps_pkg::MODE_CODE_CONV;
                        emit(owps_pkg::ACT_STAMP, 0, '0);
                    end
                    else
                    begin
                        m_count = '0;
                        m_mode = owps_pkg::MODE_CODE_WAIT;
                        emit(owps_pkg::ACT_FAILALL, 0, '0);
                        emit(owps_pkg::ACT_RELEASE, 0, '0);
                    end
                end
            end
            owps_pkg::REQ_POLL_ST:
            begin
                if (m_mode == owps_pkg::MODE_CODE_POLL && ev.status != owps_pkg::STATUS_BUSY)
                begin
                    if (ev.status != owps_pkg::STATUS_DONE)
                        emit(owps_pkg::ACT_FAILONE, m_slot, '0);
                    poll_next(m_slot + 1);
                end
            end
            owps_pkg::REQ_ADD:
            begin
                if (s < SLOTS && !m_present[s])
                begin
                    m_present[s] = 1'b1;
                    acc = 1'b1;
                    if (ev.wait_interval > m_max_wait) m_max_wait = ev.wait_interval;
                    if (m_mode == owps_pkg::MODE_CODE_OFF)
                    begin
                        m_limit = m_interval;
                        m_count = '0;
                        m_mode = owps_pkg::MODE_CODE_WAIT;
                    end
                end
            end
            owps_pkg::REQ_DELETE:
            begin
                if (s < SLOTS && m_present[s])
                begin
                    m_present[s] = 1'b0;
                    acc = 1'b1;
                    if (m_mode == owps_pkg::MODE_CODE_POLL && m_slot == s)
                    begin
                        emit(owps_pkg::ACT_RESTART, 0, '0);
                        poll_next(s + 1);
                    end
                end
            end
            owps_pkg::REQ_RETIME:
            begin
                if (s < SLOTS && m_present[s] && ev.wait_interval > m_max_wait)
                    m_max_wait = ev.wait_interval;
            end
            default: ;
        endcase
        if (staged.size() == 0) emit(owps_pkg::ACT_NONE, 0, '0);
        foreach (staged[k])
        begin
            staged[k].accepted = acc;
            staged[k].mode_out = m_mode;
            staged[k].last = (k == staged.size() - 1);
            expected_results.push_back(staged[k]);
        end
    endtask

    task automatic check_field(input string name, input int exp, input int got);
        if (exp != got)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            errors++;
        end
    endtask

    task automatic check_result(input owps_pkg::result_t got);
        owps_pkg::result_t exp;
        if (expected_results.size() == 0)
        begin
            $error("result with no request waiting: action %0d", got.action);
            errors++;
        end
        else
        begin
            exp = expected_results.pop_front();
            check_field("action", exp.action, got.action);
            check_field("target_slot", exp.target_slot, got.target_slot);
            check_field("command_out", exp.command_out, got.command_out);
            check_field("accepted", exp.accepted, got.accepted);
            check_field("mode_out", exp.mode_out, got.mode_out);
            check_field("last", exp.last, got.last);
        end
    endtask

    always @(posedge clk)
    begin : request_driver
        bit calm;
        calm = taken_count >= 600 && taken_count < 1000;
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
            begin
                predict_event(evt_data);
                taken_count++;
            end
            if (!evt_valid || !evt_stall)
            begin
                if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 10))
                begin
                    evt_valid <= 1'b1;
                    evt_data <= pending_events.pop_front();
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        bit calm;
        calm = taken_count >= 600 && taken_count < 1000;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall) check_result(res_data);
            res_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    function automatic owps_pkg::event_t make_event(
        input logic [2:0] req, input logic [1:0] st, input logic gr,
        input logic [owps_pkg::SLOT_W-1:0] slot,
        input logic [owps_pkg::TIMER_W-1:0] wait_val);
        owps_pkg::event_t ev;
        ev.req_type = req;
        ev.status = st;
        ev.granted = gr;
        ev.slave_slot = slot;
        ev.wait_interval = wait_val;
        return ev;
    endfunction

    task automatic push_event(input logic [2:0] req, input logic [1:0] st, input logic gr,
                              input logic [owps_pkg::SLOT_W-1:0] slot,
                              input logic [owps_pkg::TIMER_W-1:0] wait_val);
        pending_events.push_back(make_event(req, st, gr, slot, wait_val));
    endtask

    function automatic owps_pkg::event_t rand_event(input logic [2:0] req);
        return make_event(req, 2'($urandom), 1'($urandom),
                          owps_pkg::SLOT_W'($urandom), owps_pkg::TIMER_W'($urandom));
    endfunction

    function automatic logic [1:0] pick_status(input int busy_pct, input int done_pct);
        int r;
        r = $urandom_range(99);
        if (r < busy_pct) return owps_pkg::STATUS_BUSY;
        if (r < busy_pct + done_pct) return owps_pkg::STATUS_DONE;
        return 2'($urandom_range(2, 3));
    endfunction

    task automatic queue_slot_change(input int wait_hi);
        owps_pkg::event_t ev;
        int               pick;
        pick = $urandom_range(9);
        ev = rand_event(pick < 5 ? owps_pkg::REQ_ADD
                        : (pick < 8 ? owps_pkg::REQ_DELETE : owps_pkg::REQ_RETIME));
        ev.wait_interval = owps_pkg::TIMER_W'($urandom_range(wait_hi));
        pending_events.push_back(ev);
    endtask

    // One bus cycle: ticks, lock answers, broadcast status, conversion ticks
    // and poll statuses, with slot changes and occasional noise mixed in.
    task automatic queue_poll_round(input int tick_max, input int wait_hi);
        owps_pkg::event_t ev;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(3, 8))
            begin
                ev = rand_event(3'($urandom_range(7)));
                if (ev.req_type == owps_pkg::REQ_ADD || ev.req_type == owps_pkg::REQ_RETIME)
                    ev.wait_interval = owps_pkg::TIMER_W'($urandom_range(wait_hi));
                pending_events.push_back(ev);
            end
        end
        if ($urandom_range(3) == 0) queue_slot_change(wait_hi);
        repeat ($urandom_range(tick_max))
            pending_events.push_back(rand_event(owps_pkg::REQ_TICK));
        repeat ($urandom_range(1, 2))
        begin
            ev = rand_event(owps_pkg::REQ_LOCK_ANS);
            ev.granted = ($urandom_range(4) != 0);
            pending_events.push_back(ev);
        end
        if ($urandom_range(3) == 0) pending_events.push_back(rand_event(owps_pkg::REQ_TICK));
        repeat ($urandom_range(1, 2))
        begin
            ev = rand_event(owps_pkg::REQ_BCAST_ST);
            ev.status = pick_status(15, 70);
            pending_events.push_back(ev);
        end
        repeat ($urandom_range(5)) pending_events.push_back(rand_event(owps_pkg::REQ_TICK));
        repeat ($urandom_range(1, 9))
        begin
            if ($urandom_range(6) == 0) queue_slot_change(wait_hi);
            ev = rand_event(owps_pkg::REQ_POLL_ST);
            ev.status = pick_status(10, 60);
            pending_events.push_back(ev);
        end
    endtask

    task automatic write_reg(input logic [owps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [owps_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == owps_pkg::CFG_POLL_INTERVAL) m_interval = data;
        else m_command = data[owps_pkg::CMD_W-1:0];
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || evt_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int         intervals[4];
        logic [7:0] commands[4];
        intervals = '{1, 0, 3, 2};
        commands = '{8'h5A, 8'($urandom), 8'hA5, 8'($urandom)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Everything sent while off, with no device present, is ignored.
        push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_LOCK_ANS, owps_pkg::STATUS_DONE, 1'b1, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_BCAST_ST, owps_pkg::STATUS_DONE, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_POLL_ST, STATUS_FAILED, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_DELETE, owps_pkg::STATUS_BUSY, 1'b0, 3'd3, 24'd0);
        push_event(owps_pkg::REQ_RETIME, owps_pkg::STATUS_BUSY, 1'b0, 3'd5, 24'hFFFFFF);
        push_event(REQ_RESERVED, STATUS_RESERVED, 1'b1, 3'd7, 24'hFFFFFF);
        wait_idle();

        write_reg(owps_pkg::CFG_POLL_INTERVAL, 24'd0);
        write_reg(owps_pkg::CFG_BROADCAST_COMMAND, 24'hFFFFFF);
        @(negedge clk);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd2);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd7, 24'd1);
        push_event(owps_pkg::REQ_RETIME, owps_pkg::STATUS_BUSY, 1'b0, 3'd7, 24'd3);
        push_event(owps_pkg::REQ_RETIME, owps_pkg::STATUS_BUSY, 1'b0, 3'd7, 24'd1);
        push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_LOCK_ANS, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_LOCK_ANS, owps_pkg::STATUS_BUSY, 1'b1, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_BCAST_ST, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_BCAST_ST, owps_pkg::STATUS_DONE, 1'b0, 3'd0, 24'd0);
        repeat (3) push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_POLL_ST, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_POLL_ST, STATUS_FAILED, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_DELETE, owps_pkg::STATUS_BUSY, 1'b0, 3'd7, 24'd0);
        push_event(owps_pkg::REQ_TICK, owps_pkg::STATUS_BUSY, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_LOCK_ANS, owps_pkg::STATUS_BUSY, 1'b1, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_BCAST_ST, STATUS_RESERVED, 1'b0, 3'd0, 24'd0);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd7, 24'd0);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(owps_pkg::CFG_POLL_INTERVAL, owps_pkg::CFG_DATA_W'(intervals[p]));
            write_reg(owps_pkg::CFG_BROADCAST_COMMAND,
                      {16'($urandom_range(16'hFFFF)), commands[p]});
            @(negedge clk);
            while (pending_events.size() < 430) queue_poll_round(intervals[p] + 2, 3);
            wait_idle();
        end

        // Largest interval and conversion times: timers loaded with them never expire.
        write_reg(owps_pkg::CFG_POLL_INTERVAL, 24'hFFFFFF);
        write_reg(owps_pkg::CFG_BROADCAST_COMMAND, {16'($urandom_range(16'hFFFF)), 8'h00});
        @(negedge clk);
        push_event(owps_pkg::REQ_DELETE, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'd0);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'hFFFFFF);
        push_event(owps_pkg::REQ_RETIME, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'h800000);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'h7FFFFF);
        push_event(owps_pkg::REQ_DELETE, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'd0);
        push_event(owps_pkg::REQ_ADD, owps_pkg::STATUS_BUSY, 1'b0, 3'd4, 24'h123456);
        while (pending_events.size() < 60) queue_poll_round(6, 24'hFFFFFF);
        wait_idle();

        if (errors == 0)
            $display("** onewire_poll_sequencer: PASSED **");
        else
            $display("** onewire_poll_sequencer: FAILED **");
        $finish;
    end
endmodule

/* onewire_poll_sequencer.f */
rtl/owps_pkg.sv
rtl/owps_result_queue.sv
rtl/onewire_poll_sequencer.sv
tb/testbench.sv
